// ===== rtl/led_bar_frame_serializer_assert.svh =====
// Assertion macros used by the LED bar frame serializer back end.
`ifndef LED_BAR_FRAME_SERIALIZER_ASSERT_SVH
`define LED_BAR_FRAME_SERIALIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define LBFS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbfs assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define LBFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbfs assertion failed");

`endif

// ===== rtl/lbfs_pkg.sv =====
// Shared types and codes for the LED bar frame serializer.
package lbfs_pkg;

	// Request codes on the input stream
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_MASK  = 2'd1;
	localparam logic [1:0] REQ_RANGE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_COMMAND = 2'd0;
	localparam logic [1:0] CFG_ON      = 2'd1;
	localparam logic [1:0] CFG_OFF     = 2'd2;
	localparam logic [1:0] CFG_WAIT    = 2'd3;

	// Chip index width, covers the largest supported chain
	localparam int CHIP_W = 2;

	// Classified request kind
	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_START = 1'b1
	} req_kind_t;

	// Control part of a queued request
	typedef struct packed {
		req_kind_t          kind;
		logic [CHIP_W-1:0]  last_chip;
	} req_ctl_t;

	// Sequencer phase
	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_SEND  = 4'b0010,
		PH_WAIT  = 4'b0100,
		PH_LATCH = 4'b1000
	} phase_t;

endpackage

// ===== rtl/lbfs_front.sv =====
// Front end: accepts requests, classifies them and builds the lamp mask.
module lbfs_front import lbfs_pkg::*; #(
	parameter int CHANNELS  = 12,
	parameter int MAX_CHIPS = 2
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // chip_count, first_value, second_value
	input  logic [1:0]                    s_tuser,   // req_type
	input  logic                          q_full,
	output logic                          q_push,
	output req_ctl_t                      q_ctl,
	output logic [CHANNELS*MAX_CHIPS-1:0] q_mask
);

	logic [1:0]  chip_count;
	logic [11:0] first_value;
	logic [11:0] second_value;
	logic        is_start;
	logic [1:0]  n_chips;

	assign chip_count   = s_tdata[1:0];
	assign first_value  = s_tdata[13:2];
	assign second_value = s_tdata[25:14];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Classify; code 3 behaves as a tick
	assign is_start = (s_tuser == REQ_MASK) || (s_tuser == REQ_RANGE);

	// Clamp chip count to 1..MAX_CHIPS
	always_comb begin
		n_chips = chip_count;
		if (chip_count == 2'd0)
			n_chips = 2'd1;
		if (32'(n_chips) > MAX_CHIPS)
			n_chips = 2'(MAX_CHIPS);
	end

	assign q_ctl.kind      = is_start ? KIND_START : KIND_TICK;
	assign q_ctl.last_chip = CHIP_W'(n_chips - 2'd1);

	// Per-chip channel mask: bit per channel, from mask or from lit count
	always_comb begin
		logic [15:0] v;
		q_mask = '0;
		for (int c = 0; c < MAX_CHIPS; c++) begin
			if (c == 0)
				v = {4'b0, first_value};
			else if (c == 1)
				v = {4'b0, second_value};
			else
				v = '0;
			for (int i = 0; i < CHANNELS; i++) begin
				if (c < 32'(n_chips)) begin
					if (s_tuser == REQ_MASK)
						q_mask[c*CHANNELS+i] = v[i];
					else
						q_mask[c*CHANNELS+i] = (32'(v) > i);
				end
			end
		end
	end

endmodule

// ===== rtl/lbfs_fifo.sv =====
// Two-entry queue between the front end and the sequencer.
module lbfs_fifo #(
	parameter int WIDTH = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/lbfs_back.sv =====
// Back end: config registers, bit sequencer and output register.
`include "led_bar_frame_serializer_assert.svh"

module lbfs_back import lbfs_pkg::*; #(
	parameter int CHANNELS      = 12,
	parameter int MAX_CHIPS     = 2,
	parameter int WORD_BITS     = 16,
	parameter int LATCH_TOGGLES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          q_valid,
	input  req_ctl_t                      q_ctl,
	input  logic [CHANNELS*MAX_CHIPS-1:0] q_mask,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata    // data_pin, clock_pin, busy_res, rejected
);

	localparam int MW  = CHANNELS * MAX_CHIPS;
	localparam int BCW = $clog2(WORD_BITS);
	localparam int PW  = $clog2(CHANNELS + 1);
	localparam int TW  = $clog2(LATCH_TOGGLES);

	logic [15:0]          cmd_q, on_q, off_q, wait_cfg_q;
	phase_t               phase_q, phase_n;
	logic [WORD_BITS-1:0] shift_q, shift_n;
	logic [BCW-1:0]       bit_q, bit_n;
	logic [PW-1:0]        pos_q, pos_n;
	logic [CHIP_W-1:0]    chip_q, chip_n, last_q, last_n;
	logic [MW-1:0]        lamp_q, lamp_n;
	logic [15:0]          wait_q, wait_n;
	logic [TW-1:0]        tog_q, tog_n;
	logic                 data_lvl_q, data_lvl_n;
	logic                 clk_lvl_q, clk_lvl_n;
	logic                 rej_q, rej_n;
	logic                 out_valid_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= 16'd0;
			on_q       <= 16'd255;
			off_q      <= 16'd0;
			wait_cfg_q <= 16'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COMMAND: cmd_q      <= cfg_data;
				CFG_ON:      on_q       <= cfg_data;
				CFG_OFF:     off_q      <= cfg_data;
				CFG_WAIT:    wait_cfg_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// One queued request per cycle whenever the output slot can move
	assign q_pop = q_valid && (!out_valid_q || m_tready);

	// Sequencer step
	always_comb begin
		phase_n    = phase_q;
		shift_n    = shift_q;
		bit_n      = bit_q;
		pos_n      = pos_q;
		chip_n     = chip_q;
		last_n     = last_q;
		lamp_n     = lamp_q;
		wait_n     = wait_q;
		tog_n      = tog_q;
		data_lvl_n = data_lvl_q;
		clk_lvl_n  = clk_lvl_q;
		rej_n      = 1'b0;
		if (q_ctl.kind == KIND_START) begin
			if (phase_q != PH_IDLE) begin
				rej_n = 1'b1;
			end else begin
				lamp_n  = q_mask;
				last_n  = q_ctl.last_chip;
				chip_n  = '0;
				pos_n   = '0;
				bit_n   = '0;
				shift_n = cmd_q[WORD_BITS-1:0];
				phase_n = PH_SEND;
			end
		end else begin
			unique case (phase_q)
				PH_SEND: begin
					data_lvl_n = shift_q[WORD_BITS-1];
					clk_lvl_n  = ~clk_lvl_q;
					shift_n    = {shift_q[WORD_BITS-2:0], 1'b0};
					bit_n      = bit_q + 1'b1;
					if (bit_q == BCW'(WORD_BITS - 1)) begin
						bit_n = '0;
						if (pos_q == PW'(CHANNELS) && chip_q == last_q) begin
							phase_n = PH_WAIT;
							wait_n  = wait_cfg_q;
						end else if (pos_q == PW'(CHANNELS)) begin
							// next chip: command word first
							pos_n   = '0;
							chip_n  = chip_q + 1'b1;
							shift_n = cmd_q[WORD_BITS-1:0];
						end else begin
							pos_n   = pos_q + 1'b1;
							shift_n = lamp_q[0] ? on_q[WORD_BITS-1:0] : off_q[WORD_BITS-1:0];
							lamp_n  = lamp_q >> 1;
						end
					end
				end
				PH_WAIT: begin
					data_lvl_n = 1'b0;
					if (wait_q == 16'd0) begin
						phase_n = PH_LATCH;
						tog_n   = '0;
					end else begin
						wait_n = wait_q - 16'd1;
					end
				end
				PH_LATCH: begin
					data_lvl_n = ~data_lvl_q;
					tog_n      = tog_q + 1'b1;
					if (tog_q == TW'(LATCH_TOGGLES - 1)) begin
						tog_n   = '0;
						phase_n = PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	// State registers, advanced once per popped request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			shift_q    <= '0;
			bit_q      <= '0;
			pos_q      <= '0;
			chip_q     <= '0;
			last_q     <= '0;
			lamp_q     <= '0;
			wait_q     <= '0;
			tog_q      <= '0;
			data_lvl_q <= 1'b0;
			clk_lvl_q  <= 1'b0;
			rej_q      <= 1'b0;
		end else if (q_pop) begin
			phase_q    <= phase_n;
			shift_q    <= shift_n;
			bit_q      <= bit_n;
			pos_q      <= pos_n;
			chip_q     <= chip_n;
			last_q     <= last_n;
			lamp_q     <= lamp_n;
			wait_q     <= wait_n;
			tog_q      <= tog_n;
			data_lvl_q <= data_lvl_n;
			clk_lvl_q  <= clk_lvl_n;
			rej_q      <= rej_n;
		end
	end

	// Output slot; pin state is only updated together with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_pop)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, rej_q, (phase_q != PH_IDLE), clk_lvl_q, data_lvl_q};

	// Checks
	`LBFS_ASSERT_NEXT(a_rej_when_busy, q_pop && q_ctl.kind == KIND_START && phase_q != PH_IDLE, rej_q)
	`LBFS_ASSERT_NEXT(a_clk_only_in_send, q_pop && phase_q != PH_SEND, $stable(clk_lvl_q))
	`LBFS_ASSERT_IMPL(a_idle_counters_clear, phase_q == PH_IDLE, bit_q == '0 && tog_q == '0)
	`LBFS_ASSERT_NEXT(a_hold_while_stalled, !q_pop, $stable(data_lvl_q) && $stable(phase_q))

endmodule

// ===== rtl/led_bar_frame_serializer.sv =====
// An accepted request is stored in the queue and popped into the sequencer state registers when
// the output slot can move; m_tdata shows the result. Throughput: one request per cycle while the
// output is not stalled; the sequencer advances one pin step per request.
// A two-entry queue sits between the request front end and the sequencer.
// Reset (arst_n low, asynchronous): sequencer idle, pins low, queue and output empty,
// config registers return to command 0, on 255, off 0, latch wait 10.
module led_bar_frame_serializer import lbfs_pkg::*; #(
	parameter int CHANNELS      = 12,
	parameter int MAX_CHIPS     = 2,
	parameter int WORD_BITS     = 16,
	parameter int LATCH_TOGGLES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // chip_count[1:0], first_value[13:2], second_value[25:14]
	input  logic [1:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // data_pin[0], clock_pin[1], busy_res[2], rejected[3]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MW = CHANNELS * MAX_CHIPS;
	localparam int QW = $bits(req_ctl_t) + MW;

	logic          q_full, q_push, q_pop, q_valid;
	req_ctl_t      f_ctl, b_ctl;
	logic [MW-1:0] f_mask, b_mask;
	logic [QW-1:0] q_out;

	assign cfg_ready = 1'b1;

	lbfs_front #(
		.CHANNELS  (CHANNELS),
		.MAX_CHIPS (MAX_CHIPS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_ctl    (f_ctl),
		.q_mask   (f_mask)
	);

	lbfs_fifo #(
		.WIDTH (QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_ctl, f_mask}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_out)
	);

	assign b_ctl  = q_out[QW-1:MW];
	assign b_mask = q_out[MW-1:0];

	lbfs_back #(
		.CHANNELS      (CHANNELS),
		.MAX_CHIPS     (MAX_CHIPS),
		.WORD_BITS     (WORD_BITS),
		.LATCH_TOGGLES (LATCH_TOGGLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ctl     (b_ctl),
		.q_mask    (b_mask),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== tb/lbfs_pin_board_pkg.sv =====
// Pin-level predictor and result scoreboard for the LED bar frame serializer bench.
package lbfs_pin_board_pkg;
	import lbfs_pkg::*;

	localparam int LAMPS_PER_CHIP = 12;
	localparam int WORD_LEN       = 16;
	localparam int LATCH_FLIPS    = 8;
	localparam int CHAIN_MAX      = 2;

	// One output transaction, data_pin in bit 0
	typedef struct packed {
		logic rejected;
		logic busy;
		logic clock_pin;
		logic data_pin;
	} pin_state_t;

	class pin_board;
		// register copies, reset values
		logic [15:0] command_word = 16'd0;
		logic [15:0] on_word      = 16'd255;
		logic [15:0] off_word     = 16'd0;
		logic [15:0] latch_wait   = 16'd10;

		// sequencer copy
		phase_t      ph        = PH_IDLE;
		logic [15:0] shift     = '0;
		int          bit_cnt   = 0;
		int          word_cnt  = 0;
		logic [23:0] lamps     = '0;
		int          chips     = 1;
		logic [15:0] wait_cnt  = '0;
		int          flips     = 0;
		logic        data_lvl  = 1'b0;
		logic        clk_lvl   = 1'b0;

		pin_state_t  pending_pins[$];
		int          errors    = 0;
		int          steps_checked = 0;
		int          frames    = 0;
		int          refusals  = 0;

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				CFG_COMMAND: command_word = val;
				CFG_ON:      on_word = val;
				CFG_OFF:     off_word = val;
				CFG_WAIT:    latch_wait = val;
				default: ;
			endcase
		endfunction

		// mask request passes the bits through, range lights channels below the count
		function logic [11:0] lamp_bits(logic [1:0] req, logic [11:0] val);
			if (req == REQ_MASK)
				return val;
			if (val >= LAMPS_PER_CHIP)
				return 12'hFFF;
			return (12'd1 << val) - 12'd1;
		endfunction

		// word w of the frame: command first per chip, then channel 0 upward
		function logic [15:0] word_for(int w);
			int chip;
			int pos;
			chip = w / (LAMPS_PER_CHIP + 1);
			pos  = w % (LAMPS_PER_CHIP + 1);
			if (pos == 0)
				return command_word;
			return lamps[chip * LAMPS_PER_CHIP + pos - 1] ? on_word : off_word;
		endfunction

		// advance the sequencer copy by one request and return the pin levels
		function pin_state_t predict_pins(logic [1:0] req, logic [1:0] cc,
				logic [11:0] v1, logic [11:0] v2);
			pin_state_t r;
			logic       rej;
			int         n;
			rej = 1'b0;
			if (req == REQ_MASK || req == REQ_RANGE) begin
				if (ph != PH_IDLE) begin
					rej = 1'b1;
					refusals++;
				end else begin
					n = (cc == 2'd0) ? 1 : int'(cc);
					if (n > CHAIN_MAX)
						n = CHAIN_MAX;
					lamps = {12'h000, lamp_bits(req, v1)};
					if (n == 2)
						lamps[23:12] = lamp_bits(req, v2);
					chips    = n;
					word_cnt = 0;
					bit_cnt  = 0;
					shift    = word_for(0);
					ph       = PH_SEND;
					frames++;
				end
			end else if (ph == PH_SEND) begin
				data_lvl = shift[WORD_LEN-1];
				clk_lvl  = ~clk_lvl;
				shift    = shift << 1;
				bit_cnt++;
				if (bit_cnt >= WORD_LEN) begin
					bit_cnt = 0;
					word_cnt++;
					if (word_cnt >= chips * (LAMPS_PER_CHIP + 1)) begin
						ph       = PH_WAIT;
						wait_cnt = latch_wait;
					end else begin
						shift = word_for(word_cnt);
					end
				end
			end else if (ph == PH_WAIT) begin
				data_lvl = 1'b0;
				if (wait_cnt == 16'd0) begin
					ph    = PH_LATCH;
					flips = 0;
				end else begin
					wait_cnt--;
				end
			end else if (ph == PH_LATCH) begin
				data_lvl = ~data_lvl;
				flips++;
				if (flips >= LATCH_FLIPS) begin
					flips = 0;
					ph    = PH_IDLE;
				end
			end
			r.data_pin  = data_lvl;
			r.clock_pin = clk_lvl;
			r.busy      = (ph != PH_IDLE);
			r.rejected  = rej;
			return r;
		endfunction

		function void note_request(logic [1:0] req, logic [1:0] cc,
				logic [11:0] v1, logic [11:0] v2);
			pending_pins.push_back(predict_pins(req, cc, v1, v2));
		endfunction

		function void check_pins(pin_state_t got);
			pin_state_t want;
			if (pending_pins.size() == 0) begin
				$error("output transaction %h with no request waiting", got);
				errors++;
				return;
			end
			want = pending_pins.pop_front();
			steps_checked++;
			if (got.data_pin !== want.data_pin) begin
				$error("data_pin: expected %0d, got %0d", want.data_pin, got.data_pin);
				errors++;
			end
			if (got.clock_pin !== want.clock_pin) begin
				$error("clock_pin: expected %0d, got %0d", want.clock_pin, got.clock_pin);
				errors++;
			end
			if (got.busy !== want.busy) begin
				$error("busy_res: expected %0d, got %0d", want.busy, got.busy);
				errors++;
			end
			if (got.rejected !== want.rejected) begin
				$error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== tb/led_bar_frame_serializer_test.sv =====
// Stimulus, stall control and checking for the LED bar frame serializer.
module led_bar_frame_serializer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lbfs_pkg::*;
	import lbfs_pin_board_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;   // undefined code, acts as a tick
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // chip_count[1:0], first_value[13:2], second_value[25:14]
	logic [1:0]  s_tuser;   // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // data_pin[0], clock_pin[1], busy_res[2], rejected[3]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	pin_board board;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_req;
	int rx_hold_left;
	int quiet_cycles;
	int settings_used;

	led_bar_frame_serializer u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: long hold-off on request, otherwise random stalls
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req - 1;
			rx_hold_req = 0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_pins(pin_state_t'(m_tdata[3:0]));
	end

	// Watchdog: cycles without any transaction on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// One request transaction, with random sender gaps ahead of it
	task automatic send_item(logic [1:0] req, logic [1:0] cc, logic [11:0] v1,
			logic [11:0] v2);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {6'b0, v2, v1, cc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(req, cc, v1, v2);
	endtask

	// Stop offering until every predicted result has been seen
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending_pins.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Tick until the frame and its latch are done
	task automatic finish_frame();
		while (board.ph != PH_IDLE)
			send_item(REQ_TICK, 2'($urandom), 12'($urandom), 12'($urandom));
	endtask

	// All four registers in one burst; block must be idle
	task automatic program_regs(logic [15:0] cmd, logic [15:0] on_w, logic [15:0] off_w,
			logic [15:0] wait_t);
		logic [15:0] vals[4];
		vals = '{cmd, on_w, off_w, wait_t};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			board.set_reg(2'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Random request biased by the predicted sequencer phase
	task automatic random_item();
		logic [1:0]  req;
		logic [1:0]  cc;
		logic [11:0] v1;
		logic [11:0] v2;
		int          roll;
		int          pick;
		roll = $urandom_range(99);
		pick = $urandom_range(9);
		cc = (pick < 5) ? 2'd1 : (pick < 8) ? 2'd2 : (pick == 8) ? 2'd0 : 2'd3;
		v1 = 12'($urandom);
		v2 = 12'($urandom);
		if (board.ph == PH_IDLE) begin
			if (roll < 35)
				req = REQ_MASK;
			else if (roll < 70)
				req = REQ_RANGE;
			else if (roll < 90)
				req = REQ_TICK;
			else
				req = REQ_SPARE;
		end else begin
			if (roll < 90)
				req = REQ_TICK;
			else if (roll < 94)
				req = REQ_SPARE;
			else if (roll < 97)
				req = REQ_MASK;
			else
				req = REQ_RANGE;
		end
		// lit counts mostly around the channel count
		if (req == REQ_RANGE && $urandom_range(3) != 0) begin
			v1 = 12'($urandom_range(0, 14));
			v2 = 12'($urandom_range(0, 14));
		end
		send_item(req, cc, v1, v2);
	endtask

	task automatic run_phase(int count, int tx_pct, int rx_pct, int hold_at, int pause_at);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				rx_hold_req = HOLD_CYCLES;
			if (i == pause_at)
				settle();
			random_item();
		end
		finish_frame();
		settle();
	endtask

	initial begin
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_TICK;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_COMMAND;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_req = 0;
		rx_hold_left = 0;
		quiet_cycles = 0;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset register values, two-chip frame, refusals while busy
		send_item(REQ_TICK, 2'd0, 12'h000, 12'h000);
		send_item(REQ_MASK, 2'd2, 12'hFFF, 12'h000);
		repeat (20) send_item(REQ_TICK, 2'd3, 12'hFFF, 12'hFFF);
		send_item(REQ_RANGE, 2'd1, 12'd3, 12'd3);
		send_item(REQ_SPARE, 2'd2, 12'h0F0, 12'h0F0);
		send_item(REQ_MASK, 2'd1, 12'hFFF, 12'hFFF);
		finish_frame();
		settle();

		// Random phases across register settings and stall patterns
		run_phase(120, 0, 0, 60, -1);
		program_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'd0);
		run_phase(120, 53, 0, -1, 60);
		program_regs(16'h8001, 16'hAAAA, 16'h5555, 16'($urandom_range(0, 40)));
		run_phase(120, 0, 53, 50, -1);
		program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'd1);
		run_phase(120, 32, 32, 80, 30);
		repeat (8) @(posedge clk);

		$display("Checked %0d pin steps: %0d frames started, %0d starts refused while busy,",
			board.steps_checked, board.frames, board.refusals);
		$display("over %0d register settings with no, sender, receiver and mixed stalls.",
			settings_used);
		if (board.errors == 0 && board.pending_pins.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
